FILE: sv/lkv_pkg.sv
// shared types and constants for the lru key-value cache
package lkv_pkg;

	localparam int DEF_ENTRIES = 16;
	localparam int MAX_IDX_W   = 8;
	localparam int KEY_W       = 32;
	localparam int DATA_W      = 32;
	localparam int CAP_W       = 5;

	localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
	localparam logic              FUNC_GET   = 1'b0;
	localparam logic              FUNC_PUT   = 1'b1;
	localparam logic [DATA_W-1:0] MISS_VALUE = {DATA_W{1'b1}};
	localparam logic [DATA_W-1:0] PUT_VALUE  = '0;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_CMP    = 5'b00100,
		ST_UPDATE = 5'b01000,
		ST_FINISH = 5'b10000
	} lkv_state_t;

	// recency update: insert ages every other valid entry, otherwise only those
	// more recent than thr
	typedef struct packed {
		logic                 en;
		logic                 insert;
		logic [MAX_IDX_W-1:0] slot;
		logic [MAX_IDX_W-1:0] thr;
	} rec_upd_t;

	typedef struct packed {
		logic                 key_re;
		logic [MAX_IDX_W-1:0] key_raddr;
		logic                 val_re;
		logic [MAX_IDX_W-1:0] val_raddr;
		logic                 key_we;
		logic                 val_we;
		logic [MAX_IDX_W-1:0] waddr;
	} store_cmd_t;

endpackage

FILE: sv/lkv_store.sv
// key and value memories with registered read ports
module lkv_store import lkv_pkg::*; #(
	parameter int ENTRIES = DEF_ENTRIES
) (
	input  logic              clk,
	input  store_cmd_t        cmd,
	input  logic [KEY_W-1:0]  wkey,
	input  logic [DATA_W-1:0] wval,
	output logic [KEY_W-1:0]  rd_key_q,
	output logic [DATA_W-1:0] rd_val_q
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic [KEY_W-1:0]  key_mem [ENTRIES];
	logic [DATA_W-1:0] val_mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (cmd.key_we) begin
			key_mem[cmd.waddr[IW-1:0]] <= wkey;
		end
		if (cmd.key_re) begin
			rd_key_q <= key_mem[cmd.key_raddr[IW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.val_we) begin
			val_mem[cmd.waddr[IW-1:0]] <= wval;
		end
		if (cmd.val_re) begin
			rd_val_q <= val_mem[cmd.val_raddr[IW-1:0]];
		end
	end

endmodule

FILE: sv/lkv_recency.sv
// valid bits, per-entry recency ranks and occupancy count
module lkv_recency import lkv_pkg::*; #(
	parameter int ENTRIES = DEF_ENTRIES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rec_upd_t                            upd,
	output logic [ENTRIES-1:0]                  valid_q,
	output logic [ENTRIES-1:0][((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rank_q,
	output logic [$clog2(ENTRIES+1)-1:0]        occ_q
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OW = $clog2(ENTRIES+1);

	logic [IW-1:0] slot;
	logic [IW-1:0] thr;

	assign slot = upd.slot[IW-1:0];
	assign thr  = upd.thr[IW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rank_q  <= '0;
			occ_q   <= '0;
		end else if (upd.en) begin
			for (int j = 0; j < ENTRIES; j++) begin
				if (IW'(j) == slot) begin
					valid_q[j] <= 1'b1;
					rank_q[j]  <= '0;
				end else if (valid_q[j] && (upd.insert || rank_q[j] < thr)) begin
					rank_q[j] <= rank_q[j] + IW'(1);
				end
			end
			// replacing a victim keeps the count, a free slot grows it
			if (upd.insert && !valid_q[slot]) begin
				occ_q <= occ_q + OW'(1);
			end
		end
	end

endmodule

FILE: sv/lru_key_value_cache.sv
// lru key-value cache top level: request sequencer and shared key comparator
//
// Fully associative key-value cache with least-recently-used replacement. Each
// transaction on the input side is a get (func 0) or a put (func 1); each gives
// exactly one result: hit, and read_value holding the stored value on a get hit,
// all ones on a get miss and zero on a put. One key comparator walks the key
// memory one entry per cycle; a request passes the scan, compare, update and
// finish states before its result is offered, and the next request is taken
// only once that result is in the output register. The result sits in an output
// register, so a new request can be accepted while it waits. The capacity
// register (0 reads as 1, values above ENTRIES read as ENTRIES) is written with
// cfg_we and should change only while the cache is idle; lowering it does not
// drop entries at once. The store comes out of reset empty, with no clearing.
module lru_key_value_cache import lkv_pkg::*; #(
	parameter int ENTRIES = DEF_ENTRIES
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     func,
	input  logic signed [KEY_W-1:0]  key,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     hit,
	output logic signed [DATA_W-1:0] read_value,
	input  logic                     cfg_we,
	input  logic [CAP_W-1:0]         cfg_wdata
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OW = $clog2(ENTRIES+1);
	localparam int CW = (OW > CAP_W) ? OW : CAP_W;

	lkv_state_t          state_q;
	logic [CAP_W-1:0]    capacity_q;
	logic                func_q;
	logic [KEY_W-1:0]    req_key_q;
	logic [DATA_W-1:0]   req_val_q;
	logic [IW-1:0]       scan_q;
	logic                chk_vld_s1;
	logic [IW-1:0]       chk_idx_s1;
	logic                hit_q;
	logic [IW-1:0]       hit_idx_q;
	logic [IW-1:0]       hit_rank_q;
	logic                free_found_q;
	logic [IW-1:0]       free_idx_q;
	logic [IW-1:0]       vict_idx_q;
	logic                out_valid_q;
	logic                out_hit_q;
	logic [DATA_W-1:0]   out_data_q;

	store_cmd_t          cmd;
	rec_upd_t            upd;
	logic [KEY_W-1:0]    rd_key;
	logic [DATA_W-1:0]   rd_val;
	logic [ENTRIES-1:0]  valid_vec;
	logic [ENTRIES-1:0][IW-1:0] rank_vec;
	logic [OW-1:0]       occ;

	logic                accept;
	logic                key_match;
	logic                is_victim;
	logic [CW-1:0]       cap_ext;
	logic [CW-1:0]       eff_cap;
	logic                full;
	logic                out_load;
	logic [DATA_W-1:0]   result;

	lkv_store #(.ENTRIES(ENTRIES)) u_store (
		.clk      (clk),
		.cmd      (cmd),
		.wkey     (req_key_q),
		.wval     (req_val_q),
		.rd_key_q (rd_key),
		.rd_val_q (rd_val)
	);

	lkv_recency #(.ENTRIES(ENTRIES)) u_recency (
		.clk     (clk),
		.arst_n  (arst_n),
		.upd     (upd),
		.valid_q (valid_vec),
		.rank_q  (rank_vec),
		.occ_q   (occ)
	);

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign out_valid  = out_valid_q;
	assign hit        = out_hit_q;
	assign read_value = out_data_q;

	// shared comparator on the entry read in the previous cycle
	assign key_match = chk_vld_s1 && valid_vec[chk_idx_s1] && (rd_key == req_key_q);
	// ranks of valid entries run 0..occ-1, so the oldest holds occ-1
	assign is_victim = chk_vld_s1 && valid_vec[chk_idx_s1] &&
		(OW'(rank_vec[chk_idx_s1]) == occ - OW'(1));

	always_comb begin
		cap_ext = CW'(capacity_q);
		if (cap_ext == '0) begin
			eff_cap = CW'(1);
		end else if (cap_ext > CW'(ENTRIES)) begin
			eff_cap = CW'(ENTRIES);
		end else begin
			eff_cap = cap_ext;
		end
	end

	assign full = (CW'(occ) >= eff_cap);

	always_comb begin
		cmd           = '0;
		upd           = '0;
		cmd.key_re    = (state_q == ST_SCAN);
		cmd.key_raddr = MAX_IDX_W'(scan_q);
		if (state_q == ST_UPDATE) begin
			if (hit_q) begin
				upd.en     = 1'b1;
				upd.slot   = MAX_IDX_W'(hit_idx_q);
				upd.thr    = MAX_IDX_W'(hit_rank_q);
				cmd.waddr  = MAX_IDX_W'(hit_idx_q);
				if (func_q == FUNC_PUT) begin
					cmd.val_we = 1'b1;
				end else begin
					cmd.val_re    = 1'b1;
					cmd.val_raddr = MAX_IDX_W'(hit_idx_q);
				end
			end else if (func_q == FUNC_PUT) begin
				upd.en      = 1'b1;
				upd.insert  = 1'b1;
				upd.slot    = full ? MAX_IDX_W'(vict_idx_q) : MAX_IDX_W'(free_idx_q);
				cmd.waddr   = upd.slot;
				cmd.key_we  = 1'b1;
				cmd.val_we  = 1'b1;
			end
		end
	end

	always_comb begin
		if (func_q == FUNC_PUT) begin
			result = PUT_VALUE;
		end else if (hit_q) begin
			result = rd_val;
		end else begin
			result = MISS_VALUE;
		end
	end

	assign out_load = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			scan_q       <= '0;
			chk_vld_s1   <= 1'b0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			chk_vld_s1 <= (state_q == ST_SCAN);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (key_match) begin
				hit_q <= 1'b1;
			end
			if (chk_vld_s1 && !valid_vec[chk_idx_s1] && !free_found_q) begin
				free_found_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						scan_q       <= '0;
						hit_q        <= 1'b0;
						free_found_q <= 1'b0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_q == IW'(ENTRIES-1)) begin
						state_q <= ST_CMP;
					end else begin
						scan_q <= scan_q + IW'(1);
					end
				end
				ST_CMP: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q    <= func;
			req_key_q <= key;
			req_val_q <= value;
		end
		chk_idx_s1 <= scan_q;
		if (key_match) begin
			hit_idx_q  <= chk_idx_s1;
			hit_rank_q <= rank_vec[chk_idx_s1];
		end
		if (chk_vld_s1 && !valid_vec[chk_idx_s1] && !free_found_q) begin
			free_idx_q <= chk_idx_s1;
		end
		if (is_victim) begin
			vict_idx_q <= chk_idx_s1;
		end
		if (out_load) begin
			out_hit_q  <= hit_q;
			out_data_q <= result;
		end
	end

	// occupancy always matches the number of valid entries
	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == occ)
		else $error("occupancy out of step with valid entries");

	// entries are never dropped, so occupancy never shrinks
	a_occ_mono: assert property (@(posedge clk) disable iff (!arst_n)
		occ >= $past(occ))
		else $error("occupancy decreased");

	// a put that misses into a full store replaces a victim and does not grow occupancy
	a_cap_respected: assert property (@(posedge clk) disable iff (!arst_n)
		upd.en && upd.insert && full |=> occ == $past(occ))
		else $error("insert grew a full store");

	// the store is only changed while a request is being committed
	a_upd_state: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.key_we || cmd.val_we) |-> upd.en && state_q == ST_UPDATE)
		else $error("memory write outside commit");

endmodule

FILE: verif/lru_key_value_cache_tb.sv
// self-checking testbench for the lru key-value cache
module lru_key_value_cache_tb;
	import lkv_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_SLOTS   = DEF_ENTRIES;
	localparam int RANK_W      = $clog2(NUM_SLOTS);
	localparam int SETTLE      = NUM_SLOTS + 8;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 4000;
	localparam int PHASE_ITEMS = 80;
	localparam int NUM_PHASES  = 9;
	localparam int NUM_PROBES  = 17;

	typedef struct packed {
		logic              hit_bit;
		logic [DATA_W-1:0] data;
	} cache_reply_t;

	typedef struct packed {
		logic              op;
		logic [KEY_W-1:0]  k;
		logic [DATA_W-1:0] v;
		bit                typed;
		logic              e_hit;
		logic [DATA_W-1:0] e_val;
	} probe_row_t;

	// directed requests at the reset capacity; typed rows carry their own answer
	localparam probe_row_t PROBES [NUM_PROBES] = '{
		'{FUNC_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, MISS_VALUE},
		'{FUNC_GET, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, MISS_VALUE},
		'{FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, PUT_VALUE},
		'{FUNC_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF},
		'{FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0, PUT_VALUE},
		'{FUNC_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000},
		'{FUNC_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, PUT_VALUE},
		// stored all-ones value reads back exactly like a miss value
		'{FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
		'{FUNC_PUT, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, PUT_VALUE},
		'{FUNC_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
		'{FUNC_PUT, 32'h8000_0000, 32'h1234_5678, 1'b1, 1'b1, PUT_VALUE},
		'{FUNC_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h1234_5678},
		'{FUNC_GET, 32'hFFFF_FFFE, 32'h5555_5555, 1'b1, 1'b0, MISS_VALUE},
		'{FUNC_PUT, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b0, PUT_VALUE},
		'{FUNC_PUT, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0, PUT_VALUE},
		'{FUNC_GET, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0, PUT_VALUE},
		'{FUNC_GET, 32'hAAAA_AAAA, 32'h0000_0000, 1'b0, 1'b0, PUT_VALUE}
	};

	// zero, one and both saturating extremes, plus lowering below the fill level
	localparam logic [CAP_W-1:0] CAP_PLAN [NUM_PHASES] = '{
		5'd31, 5'd2, 5'd0, 5'd1, 5'd16, 5'd3, 5'd17, 5'd9, 5'd16
	};

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic                     func = FUNC_GET;
	logic signed [KEY_W-1:0]  key = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic                     hit;
	logic signed [DATA_W-1:0] read_value;
	logic                     cfg_we = 1'b0;
	logic [CAP_W-1:0]         cfg_wdata = '0;

	// shadow copy of the cache contents
	logic [KEY_W-1:0]  shadow_key  [NUM_SLOTS];
	logic [DATA_W-1:0] shadow_val  [NUM_SLOTS];
	bit                shadow_used [NUM_SLOTS];
	logic [RANK_W-1:0] shadow_rank [NUM_SLOTS];
	logic [CAP_W-1:0]  shadow_fill = '0;
	logic [CAP_W-1:0]  shadow_cap  = CAP_RESET;

	cache_reply_t     pending_replies [$];
	logic [KEY_W-1:0] key_pool [$];
	int               mismatches = 0;
	bit               quiet = 1'b0;
	int               hold_requests = 0;
	int               hold_seen = 0;
	int               stall_left = 0;
	int               dead_cycles = 0;

	lru_key_value_cache i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.key       (key),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.hit       (hit),
		.read_value(read_value),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic int effective_cap(input logic [CAP_W-1:0] c);
		if (c == 0)
			return 1;
		if (c > NUM_SLOTS)
			return NUM_SLOTS;
		return int'(c);
	endfunction

	// mostly back to back, sometimes a short gap, rarely a long one
	function automatic int idle_cycles();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void promote_slot(input int s);
		logic [RANK_W-1:0] r;
		r = shadow_rank[s];
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (shadow_used[i] && i != s && shadow_rank[i] < r)
				shadow_rank[i]++;
		end
		shadow_rank[s] = '0;
	endfunction

	function automatic cache_reply_t lru_access(input logic op, input logic [KEY_W-1:0] k,
			input logic [DATA_W-1:0] v);
		int found;
		int victim;
		int free_slot;
		cache_reply_t rep;
		found = -1;
		victim = -1;
		free_slot = -1;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (found < 0 && shadow_used[i] && shadow_key[i] == k)
				found = i;
		end
		if (op == FUNC_GET) begin
			if (found >= 0) begin
				promote_slot(found);
				rep = '{1'b1, shadow_val[found]};
			end else begin
				rep = '{1'b0, MISS_VALUE};
			end
			return rep;
		end
		rep.data = PUT_VALUE;
		if (found >= 0) begin
			shadow_val[found] = v;
			promote_slot(found);
			rep.hit_bit = 1'b1;
			return rep;
		end
		rep.hit_bit = 1'b0;
		if (shadow_fill >= effective_cap(shadow_cap)) begin
			// overwrite the oldest entry in place
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (shadow_used[i] && (victim < 0 || shadow_rank[i] > shadow_rank[victim]))
					victim = i;
			end
			if (victim >= 0) begin
				shadow_key[victim] = k;
				shadow_val[victim] = v;
				promote_slot(victim);
				return rep;
			end
		end
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (free_slot < 0 && !shadow_used[i])
				free_slot = i;
		end
		if (free_slot >= 0) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (shadow_used[i])
					shadow_rank[i]++;
			end
			shadow_used[free_slot] = 1'b1;
			shadow_key[free_slot] = k;
			shadow_val[free_slot] = v;
			shadow_rank[free_slot] = '0;
			shadow_fill++;
		end
		return rep;
	endfunction

	task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		mismatches++;
		$display("%0t ns: %s wrong: got %h, expected %h", $time, what, got, want);
	endtask

	// offer one request and record its answer once the transaction is taken
	task automatic issue_request(input logic op, input logic [KEY_W-1:0] k,
			input logic [DATA_W-1:0] v, input bit typed, input cache_reply_t fixed);
		int gap;
		cache_reply_t rep;
		gap = idle_cycles();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= op;
		key <= k;
		value <= v;
		do @(posedge clk); while (!in_ready);
		rep = lru_access(op, k, v);
		pending_replies.push_back(typed ? fixed : rep);
	endtask

	task automatic drain_replies();
		in_valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] c);
		drain_replies();
		cfg_we <= 1'b1;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_cap = c;
	endtask

	// result side: compare, then decide next cycle's ready
	always @(posedge clk) begin : reply_check
		cache_reply_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_replies.size() == 0) begin
				flag_mismatch("unrequested result", read_value, '0);
			end else begin
				want = pending_replies.pop_front();
				if (hit !== want.hit_bit)
					flag_mismatch("hit", DATA_W'(hit), DATA_W'(want.hit_bit));
				if (read_value !== want.data)
					flag_mismatch("read_value", read_value, want.data);
			end
		end
		if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			stall_left = HOLD_CYCLES;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			stall_left = idle_cycles();
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			dead_cycles <= 0;
		end else if (dead_cycles >= STALL_LIMIT) begin
			$display("no transaction for %0d cycles", STALL_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			dead_cycles <= dead_cycles + 1;
		end
	end

	initial begin
		int pool_size;
		logic [KEY_W-1:0] k;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			shadow_key[i] = '0;
			shadow_val[i] = '0;
			shadow_used[i] = 1'b0;
			shadow_rank[i] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (PROBES[i])
			issue_request(PROBES[i].op, PROBES[i].k, PROBES[i].v, PROBES[i].typed,
				'{PROBES[i].e_hit, PROBES[i].e_val});

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_capacity(CAP_PLAN[p]);
			quiet = (p == 0 || p == 5);
			if (p == 3)
				hold_requests <= hold_requests + 1;
			// a few more keys than fit, so hits and evictions both happen
			pool_size = effective_cap(CAP_PLAN[p]) + 1 + $urandom_range(0, 4);
			key_pool.delete();
			repeat (pool_size) begin
				case ($urandom_range(0, 15))
					0:       key_pool.push_back(32'h0000_0000);
					1:       key_pool.push_back(32'hFFFF_FFFF);
					2:       key_pool.push_back(32'h8000_0000);
					3:       key_pool.push_back(32'h7FFF_FFFF);
					default: key_pool.push_back($urandom);
				endcase
			end
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(0, 99) < 85)
					k = key_pool[$urandom_range(0, key_pool.size() - 1)];
				else
					k = $urandom;
				issue_request(1'($urandom_range(0, 1)), k, $urandom, 1'b0, '0);
			end
		end

		drain_replies();
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: filelist.f
sv/lkv_pkg.sv
sv/lkv_store.sv
sv/lkv_recency.sv
sv/lru_key_value_cache.sv
verif/lru_key_value_cache_tb.sv
